### design/gnho_pkg.sv
// Package with the types, constants and saturating helpers of the Gear Nose-Hoover step.
`default_nettype none
package gnho_pkg;

   localparam int GEAR_ORDER = 6;

   typedef logic signed [63:0] q_type;

   localparam q_type Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q_type Q_MIN = 64'sh8000_0000_0000_0000;

   // Register indexes of the control port.
   localparam logic [2:0] CSR_NVE_MODE     = 3'd0;
   localparam logic [2:0] CSR_HALF_DT_SQ   = 3'd1;
   localparam logic [2:0] CSR_INV_DT       = 3'd2;
   localparam logic [2:0] CSR_INV_TAU_SQ   = 3'd3;
   localparam logic [2:0] CSR_INV_TEMP     = 3'd4;
   localparam logic [2:0] CSR_INTERVAL     = 3'd5;

   localparam logic [62:0] RST_HALF_DT_SQ = 63'd1407375;
   localparam logic [62:0] RST_INV_DT     = 63'd2814749767106560000;
   localparam logic [62:0] RST_INV_TAU_SQ = 63'd1111218700000000000;
   localparam logic [62:0] RST_INV_TEMP   = 63'd281474976710656;
   localparam logic [15:0] RST_INTERVAL   = 16'd1000;

   // Pascal matrix, row k and column j.
   localparam logic [3:0] PASCAL [GEAR_ORDER][GEAR_ORDER] = '{
      '{4'd1, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0},
      '{4'd1, 4'd1, 4'd0,  4'd0,  4'd0, 4'd0},
      '{4'd1, 4'd2, 4'd1,  4'd0,  4'd0, 4'd0},
      '{4'd1, 4'd3, 4'd3,  4'd1,  4'd0, 4'd0},
      '{4'd1, 4'd4, 4'd6,  4'd4,  4'd1, 4'd0},
      '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1}
   };

   localparam logic [8:0] GEAR_NUM [GEAR_ORDER] = '{9'd3, 9'd251, 9'd1, 9'd11, 9'd1, 9'd1};
   localparam logic [8:0] GEAR_DEN [GEAR_ORDER] = '{9'd16, 9'd360, 9'd1, 9'd18, 9'd6, 9'd60};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_V0,
      OP_SQ0,
      OP_VZ,
      OP_TT,
      OP_ZACC,
      OP_PD,
      OP_PG,
      OP_ZD,
      OP_ZG,
      OP_V1,
      OP_ZR,
      OP_XX,
      OP_SQ1
   } op_type;

   function automatic q_type sat_add(input q_type a, input q_type b);
      q_type s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return Q_MAX;
      if (a[63] && b[63] && !s[63]) return Q_MIN;
      return s;
   endfunction

   function automatic q_type sat_sub(input q_type a, input q_type b);
      if (b == Q_MIN) begin
         if (!a[63]) return Q_MAX;
         return a - b;
      end
      return sat_add(a, -b);
   endfunction

   // Subtracts or adds the wrap distance once when the position leaves the box.
   function automatic q_type wrap_pos(input q_type x, input q_type w);
      if (x > w) return x - w;
      if (x < -w) return x + w;
      return x;
   endfunction

   // Gear coefficient by restoring long division, rounded to nearest.
   function automatic q_type gear_const(input int j, input int fb);
      logic [63:0] q;
      logic [9:0]  r;
      logic [9:0]  den;
      q   = '0;
      den = {1'b0, GEAR_DEN[j]};
      r   = {1'b0, GEAR_NUM[j]};
      if (r >= den) begin
         q = 64'd1;
         r = r - den;
      end
      for (int i = 0; i < fb; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            q = q | 64'd1;
            r = r - den;
         end
      end
      if ((r << 1) >= den) q = q + 64'd1;
      return q_type'(q);
   endfunction

endpackage
`default_nettype wire

### design/gear_nose_hoover_oscillator_step.sv
// Top level of the sixth-order Gear predictor-corrector step with Nose-Hoover thermostat.
//
//   Channel   Ports    Direction   Carries
//   request   req_*    in          one advance transaction
//   response  rsp_*    out         one report transaction every report_interval steps
//   control   csr_*    in          register writes, no handshake
//
// An advance transaction with advance set runs the saturating Pascal sums, then its products
// (fewer with nve_mode set) in the shared multiplier, which builds a 64 by 64 product from
// four 32 by 32 partials. A transaction with advance clear is accepted and changes nothing.
// Reset is synchronous and restores the control registers, derivative vectors and counter.
// A pending report waits in the response register; a new request is accepted meanwhile, and
// the block stalls only when a second report is ready before the first is taken.
`default_nettype none
module gear_nose_hoover_oscillator_step
   import gnho_pkg::*;
#(
   parameter int FRACTION_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_advance,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_step_index,
   output q_type            rsp_position,
   output q_type            rsp_velocity,
   output q_type            rsp_thermostat_var,
   output q_type            rsp_thermostat_rate,
   output q_type            rsp_potential_energy,
   output logic [62:0]      rsp_kinetic_energy,
   output logic [62:0]      rsp_temperature,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [62:0] csr_wdata
);

   localparam q_type ONE      = q_type'(64'd1 << FRACTION_BITS);
   localparam q_type HALF_ONE = q_type'(64'd1 << (FRACTION_BITS - 1));
   localparam q_type WRAP     = q_type'(64'd20 << FRACTION_BITS);
   localparam q_type GEAR_K [GEAR_ORDER] = '{
      gear_const(0, FRACTION_BITS), gear_const(1, FRACTION_BITS),
      gear_const(2, FRACTION_BITS), gear_const(3, FRACTION_BITS),
      gear_const(4, FRACTION_BITS), gear_const(5, FRACTION_BITS)
   };

   // Control registers.
   logic        nve_ff;
   logic [62:0] hdt2_ff, inv_dt_ff, inv_tau2_ff, inv_temp_ff;
   logic [15:0] interval_ff;

   // Integrator state and step scratch.
   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [2:0]  g_ff, g_in;
   q_type       pd_ff [GEAR_ORDER];
   q_type       pd_in [GEAR_ORDER];
   q_type       zd_ff [GEAR_ORDER];
   q_type       zd_in [GEAR_ORDER];
   q_type       pp_ff [GEAR_ORDER];
   q_type       pp_in [GEAR_ORDER];
   q_type       pz_ff [GEAR_ORDER];
   q_type       pz_in [GEAR_ORDER];
   q_type       zr_ff, zr_in;
   q_type       v_ff, v_in;
   q_type       temp_ff, temp_in;
   q_type       acc_ff, acc_in;
   q_type       zacc_ff, zacc_in;
   q_type       d_ff, d_in;
   q_type       pot_ff, pot_in;
   q_type       kin_ff, kin_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] idx_ff, idx_in;

   // Pascal-sum sequencer.
   logic [2:0]  pj_ff, pj_in, pk_ff, pk_in;
   logic [3:0]  pn_ff, pn_in;
   q_type       sp_ff, sp_in, sz_ff, sz_in;
   logic        pred_last;

   // Step index modulo interval, one quotient bit per cycle.
   logic [15:0] iv_ff, iv_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [5:0]  rcnt_ff, rcnt_in;
   logic [16:0] trial;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_idx_ff, o_idx_in;
   q_type       o_x_ff, o_x_in, o_v_ff, o_v_in, o_z_ff, o_z_in, o_zr_ff, o_zr_in;
   q_type       o_pot_ff, o_pot_in;
   logic [62:0] o_kin_ff, o_kin_in, o_temp_ff, o_temp_in;

   // Shared multiplier.
   logic        mul_start, mul_done;
   q_type       mul_a, mul_b, mul_res;

   q_type       x_pred, x_cor;
   logic [3:0]  coef;
   q_type       sp_new, sz_new;
   logic        accept;
   logic        out_free;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign x_pred    = wrap_pos(pp_ff[0], WRAP);
   assign x_cor     = wrap_pos(pd_ff[0], WRAP);
   assign coef      = PASCAL[pk_ff][pj_ff];
   assign sp_new    = sat_add(sp_ff, pd_ff[pk_ff]);
   assign sz_new    = sat_add(sz_ff, zd_ff[pk_ff]);
   assign pred_last = (pn_ff + 4'd1 == coef) && (pk_ff == 3'd5) && (pj_ff == 3'd5);
   assign trial     = {rem_ff, div_ff[31]};

   gnho_mul #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Operand selection for the operation in flight.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_V0: begin
            mul_a = pp_ff[1];
            mul_b = q_type'({1'b0, inv_dt_ff});
         end
         OP_SQ0: begin
            mul_a = v_ff;
            mul_b = v_ff;
         end
         OP_VZ: begin
            mul_a = v_ff;
            mul_b = zr_ff;
         end
         OP_TT: begin
            mul_a = temp_ff;
            mul_b = q_type'({1'b0, inv_temp_ff});
         end
         OP_ZACC: begin
            mul_a = q_type'({1'b0, inv_tau2_ff});
            mul_b = d_ff;
         end
         OP_PD: begin
            mul_a = q_type'({1'b0, hdt2_ff});
            mul_b = acc_ff;
         end
         OP_PG, OP_ZG: begin
            mul_a = GEAR_K[g_ff];
            mul_b = d_ff;
         end
         OP_ZD: begin
            mul_a = q_type'({1'b0, hdt2_ff});
            mul_b = zacc_ff;
         end
         OP_V1: begin
            mul_a = pd_ff[1];
            mul_b = q_type'({1'b0, inv_dt_ff});
         end
         OP_ZR: begin
            mul_a = zd_ff[1];
            mul_b = q_type'({1'b0, inv_dt_ff});
         end
         OP_XX: begin
            mul_a = x_cor;
            mul_b = x_cor;
         end
         OP_SQ1: begin
            mul_a = v_ff;
            mul_b = v_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept && req_advance) state_in = ST_PREDICT;
         ST_PREDICT: if (pred_last) state_in = ST_ISSUE;
         ST_ISSUE:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (mul_done) begin
               if (op_ff != OP_SQ1) state_in = ST_ISSUE;
               else if (rem_ff == 16'd0) state_in = ST_EMIT;
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_start = (state_ff == ST_ISSUE);
      op_in     = op_ff;
      g_in      = g_ff;
      pd_in     = pd_ff;
      zd_in     = zd_ff;
      pp_in     = pp_ff;
      pz_in     = pz_ff;
      zr_in     = zr_ff;
      v_in      = v_ff;
      temp_in   = temp_ff;
      acc_in    = acc_ff;
      zacc_in   = zacc_ff;
      d_in      = d_ff;
      pot_in    = pot_ff;
      kin_in    = kin_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pj_in     = pj_ff;
      pk_in     = pk_ff;
      pn_in     = pn_ff;
      sp_in     = sp_ff;
      sz_in     = sz_ff;
      iv_in     = iv_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      rcnt_in   = rcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_idx_in  = o_idx_ff;
      o_x_in    = o_x_ff;
      o_v_in    = o_v_ff;
      o_z_in    = o_z_ff;
      o_zr_in   = o_zr_ff;
      o_pot_in  = o_pot_ff;
      o_kin_in  = o_kin_ff;
      o_temp_in = o_temp_ff;

      // The remainder runs beside the Pascal sums, which always last longer.
      if (rcnt_ff != 6'd32) begin
         if (trial >= {1'b0, iv_ff}) rem_in = 16'(trial - {1'b0, iv_ff});
         else rem_in = trial[15:0];
         div_in  = div_ff << 1;
         rcnt_in = rcnt_ff + 6'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_advance) begin
               idx_in   = count_ff;
               count_in = count_ff + 32'd1;
               div_in   = count_ff;
               rem_in   = '0;
               rcnt_in  = '0;
               iv_in    = (interval_ff == 16'd0) ? 16'd1 : interval_ff;
               pj_in    = '0;
               pk_in    = '0;
               pn_in    = '0;
               sp_in    = '0;
               sz_in    = '0;
            end
         end
         ST_PREDICT: begin
            // Column j sums c[k] pascal(k,j) times, saturating after each add.
            if (pn_ff + 4'd1 == coef) begin
               pn_in = '0;
               if (pk_ff == 3'd5) begin
                  pp_in[pj_ff] = sp_new;
                  pz_in[pj_ff] = sz_new;
                  sp_in = '0;
                  sz_in = '0;
                  pj_in = pj_ff + 3'd1;
                  pk_in = pj_ff + 3'd1;
               end else begin
                  sp_in = sp_new;
                  sz_in = sz_new;
                  pk_in = pk_ff + 3'd1;
               end
            end else begin
               sp_in = sp_new;
               sz_in = sz_new;
               pn_in = pn_ff + 4'd1;
            end
            op_in = OP_V0;
         end
         ST_ISSUE: begin
         end
         ST_WAIT: begin
            if (mul_done) begin
               unique case (op_ff)
                  OP_V0: begin
                     v_in  = mul_res;
                     op_in = OP_SQ0;
                  end
                  OP_SQ0: begin
                     temp_in = mul_res >>> 2;
                     acc_in  = -x_pred;
                     if (nve_ff) begin
                        zacc_in = '0;
                        op_in   = OP_PD;
                     end else begin
                        op_in   = OP_VZ;
                     end
                  end
                  OP_VZ: begin
                     acc_in = sat_sub(acc_ff, mul_res);
                     op_in  = OP_TT;
                  end
                  OP_TT: begin
                     d_in  = sat_sub(mul_res, ONE);
                     op_in = OP_ZACC;
                  end
                  OP_ZACC: begin
                     zacc_in = mul_res;
                     op_in   = OP_PD;
                  end
                  OP_PD: begin
                     d_in  = sat_sub(mul_res, pp_ff[2]);
                     g_in  = '0;
                     op_in = OP_PG;
                  end
                  OP_PG: begin
                     pd_in[g_ff] = sat_add(pp_ff[g_ff], mul_res);
                     if (g_ff == 3'd5) op_in = OP_ZD;
                     else g_in = g_ff + 3'd1;
                  end
                  OP_ZD: begin
                     d_in  = sat_sub(mul_res, pz_ff[2]);
                     g_in  = '0;
                     op_in = OP_ZG;
                  end
                  OP_ZG: begin
                     zd_in[g_ff] = sat_add(pz_ff[g_ff], mul_res);
                     if (g_ff == 3'd5) op_in = OP_V1;
                     else g_in = g_ff + 3'd1;
                  end
                  OP_V1: begin
                     v_in  = mul_res;
                     op_in = OP_ZR;
                  end
                  OP_ZR: begin
                     zr_in = mul_res;
                     op_in = OP_XX;
                  end
                  OP_XX: begin
                     if (x_cor < -ONE || x_cor > ONE) pot_in = '0;
                     else pot_in = (mul_res >>> 1) - HALF_ONE;
                     op_in = OP_SQ1;
                  end
                  OP_SQ1: begin
                     kin_in = mul_res >>> 1;
                     op_in  = OP_V0;
                  end
                  default: op_in = OP_V0;
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_idx_in     = idx_ff;
               o_x_in       = x_cor;
               o_v_in       = v_ff;
               o_z_in       = zd_ff[0];
               o_zr_in      = zr_ff;
               o_pot_in     = pot_ff;
               o_kin_in     = kin_ff[62:0];
               o_temp_in    = 63'(kin_ff >>> 1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         nve_ff      <= 1'b0;
         hdt2_ff     <= RST_HALF_DT_SQ;
         inv_dt_ff   <= RST_INV_DT;
         inv_tau2_ff <= RST_INV_TAU_SQ;
         inv_temp_ff <= RST_INV_TEMP;
         interval_ff <= RST_INTERVAL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NVE_MODE:   nve_ff      <= csr_wdata[0];
            CSR_HALF_DT_SQ: hdt2_ff     <= csr_wdata;
            CSR_INV_DT:     inv_dt_ff   <= csr_wdata;
            CSR_INV_TAU_SQ: inv_tau2_ff <= csr_wdata;
            CSR_INV_TEMP:   inv_temp_ff <= csr_wdata;
            CSR_INTERVAL:   interval_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_V0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         zr_ff        <= '0;
         rcnt_ff      <= 6'd32;
         for (int i = 0; i < GEAR_ORDER; i++) begin
            pd_ff[i] <= '0;
            zd_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         zr_ff        <= zr_in;
         rcnt_ff      <= rcnt_in;
         pd_ff        <= pd_in;
         zd_ff        <= zd_in;
      end
      g_ff      <= g_in;
      pp_ff     <= pp_in;
      pz_ff     <= pz_in;
      v_ff      <= v_in;
      temp_ff   <= temp_in;
      acc_ff    <= acc_in;
      zacc_ff   <= zacc_in;
      d_ff      <= d_in;
      pot_ff    <= pot_in;
      kin_ff    <= kin_in;
      idx_ff    <= idx_in;
      pj_ff     <= pj_in;
      pk_ff     <= pk_in;
      pn_ff     <= pn_in;
      sp_ff     <= sp_in;
      sz_ff     <= sz_in;
      iv_ff     <= iv_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      o_idx_ff  <= o_idx_in;
      o_x_ff    <= o_x_in;
      o_v_ff    <= o_v_in;
      o_z_ff    <= o_z_in;
      o_zr_ff   <= o_zr_in;
      o_pot_ff  <= o_pot_in;
      o_kin_ff  <= o_kin_in;
      o_temp_ff <= o_temp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_index       = o_idx_ff;
   assign rsp_position         = o_x_ff;
   assign rsp_velocity         = o_v_ff;
   assign rsp_thermostat_var   = o_z_ff;
   assign rsp_thermostat_rate  = o_zr_ff;
   assign rsp_potential_energy = o_pot_ff;
   assign rsp_kinetic_energy   = o_kin_ff;
   assign rsp_temperature      = o_temp_ff;

endmodule
`default_nettype wire

### design/gnho_mul.sv
// Multi-cycle signed fixed-point multiplier with rounding and saturation.
`default_nettype none
module gnho_mul
   import gnho_pkg::*;
#(
   parameter int FRACTION_BITS = 48
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   input  wire q_type a,
   input  wire q_type b,
   output logic       done,
   output q_type      result
);

   logic [2:0]   phase_ff, phase_in;
   logic         neg_ff, neg_in;
   logic [63:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   q_type        res_ff, res_in;
   logic         done_ff, done_in;

   logic [127:0] shifted;
   logic [127:0] rounded;
   logic [63:0]  mag;
   logic [63:0]  lim;
   logic [1:0]   part;

   assign shifted = {64'd0, prod_ff} << {sh_ff, 5'd0};
   assign rounded = acc_ff + (128'd1 << (FRACTION_BITS - 1));
   assign part    = phase_ff[1:0] - 2'd1;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      prod_in  = prod_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      mag      = rounded[FRACTION_BITS +: 64];
      lim      = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (phase_ff == 3'd0) begin
         if (start) begin
            neg_in   = a[63] ^ b[63];
            ua_in    = a[63] ? (~a + 64'd1) : a;
            ub_in    = b[63] ? (~b + 64'd1) : b;
            acc_in   = '0;
            phase_in = 3'd1;
         end
      end else if (phase_ff <= 3'd4) begin
         // One 32 by 32 partial product per cycle; the previous one is summed.
         case (part)
            2'd0: begin
               prod_in = ua_ff[31:0] * ub_ff[31:0];
               sh_in   = 2'd0;
            end
            2'd1: begin
               prod_in = ua_ff[31:0] * ub_ff[63:32];
               sh_in   = 2'd1;
            end
            2'd2: begin
               prod_in = ua_ff[63:32] * ub_ff[31:0];
               sh_in   = 2'd1;
            end
            default: begin
               prod_in = ua_ff[63:32] * ub_ff[63:32];
               sh_in   = 2'd2;
            end
         endcase
         if (phase_ff != 3'd1) acc_in = acc_ff + shifted;
         phase_in = phase_ff + 3'd1;
      end else if (phase_ff == 3'd5) begin
         acc_in   = acc_ff + shifted;
         phase_in = 3'd6;
      end else begin
         if ((rounded >> (FRACTION_BITS + 64)) != 128'd0) mag = lim;
         else if (mag > lim) mag = lim;
         res_in   = neg_ff ? q_type'(~mag + 64'd1) : q_type'(mag);
         done_in  = 1'b1;
         phase_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 3'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

### design/gnho_checker.sv
// Port-level checker of the Gear Nose-Hoover step and its bind to the top level.
`default_nettype none
module gnho_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_advance,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_potential_energy,
   input wire logic [62:0] rsp_kinetic_energy,
   input wire logic [62:0] rsp_temperature
);

   // A waiting report transaction is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   // An advance transaction leaves the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_advance |=> !req_ready)
      else $error("ready right after an advance transaction");

   // A transaction without advance leaves the block ready.
   a_noop: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_advance |=> req_ready)
      else $error("busy after an ignored transaction");

   // Temperature is half of the kinetic energy, and potential energy is never positive.
   a_energy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature == (rsp_kinetic_energy >> 1)) &&
                    (rsp_potential_energy[63] || rsp_potential_energy == 64'd0))
      else $error("inconsistent energy fields");

endmodule

bind gear_nose_hoover_oscillator_step gnho_checker u_gnho_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_advance          (req_advance),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_potential_energy (rsp_potential_energy),
   .rsp_kinetic_energy   (rsp_kinetic_energy),
   .rsp_temperature      (rsp_temperature)
);
`default_nettype wire
